// File: hw/rtl/rgb_led_matrix_scan_controller_macros.svh
// assertion macros used by the scan controller state machine (rlm_ctrl)
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef RGB_LED_MATRIX_SCAN_CONTROLLER_MACROS_SVH
`define RGB_LED_MATRIX_SCAN_CONTROLLER_MACROS_SVH

// checked outside reset only
`define RLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define RLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/rlm_pkg.sv
// shared constants, action codes and controller/datapath interface types
// no dependencies
package rlm_pkg;

  // default panel geometry
  localparam int HALF_ROWS_DEF = 32;
  localparam int COLUMNS_DEF   = 64;

  // fixed field widths
  localparam int COORD_W    = 8;
  localparam int COLOR_W    = 3;
  localparam int ROW_ADDR_W = 5;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic write_en;
    logic read_en;
    logic step_column;
    logic next_row;
    logic show_latch;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic end_of_row;
  } status_t;

endpackage

// File: hw/rtl/rlm_datapath.sv
// frame store (two colour-half memories), scan counters and result fields
// depends on rlm_pkg
module rlm_datapath #(
  parameter int HALF_ROWS = rlm_pkg::HALF_ROWS_DEF,
  parameter int COLUMNS   = rlm_pkg::COLUMNS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rlm_pkg::cmd_t                         cmd_i,
  output rlm_pkg::status_t                      status_o,
  input  logic signed [rlm_pkg::COORD_W-1:0]    panel_row_i,
  input  logic signed [rlm_pkg::COORD_W-1:0]    panel_column_i,
  input  logic        [rlm_pkg::COLOR_W-1:0]    pixel_color_i,
  output logic        [rlm_pkg::COLOR_W-1:0]    lower_rgb_o,
  output logic        [rlm_pkg::COLOR_W-1:0]    upper_rgb_o,
  output logic                                  shift_pulse_o,
  output logic                                  latch_pulse_o,
  output logic                                  blank_o,
  output logic        [rlm_pkg::ROW_ADDR_W-1:0] row_address_o,
  output logic                                  last_o
);
  import rlm_pkg::*;

  localparam int DEPTH  = HALF_ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(HALF_ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  // colour halves kept apart so a write touches only its own half
  logic [COLOR_W-1:0] lo_mem_q [DEPTH];
  logic [COLOR_W-1:0] up_mem_q [DEPTH];
  logic [COLOR_W-1:0] lo_rd_q, up_rd_q;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;

  logic [COORD_W:0]  row_ext, col_ext, row_local;
  logic              row_ok, col_ok, upper_half;
  logic [ADDR_W-1:0] pix_addr, scan_addr, wr_addr;
  logic [COLOR_W-1:0] wr_data;
  logic              lo_we, up_we;

  // pixel coordinate decode
  always_comb begin
    row_ext    = {1'b0, panel_row_i};
    col_ext    = {1'b0, panel_column_i};
    row_ok     = !panel_row_i[COORD_W-1] && (row_ext < (COORD_W+1)'(2 * HALF_ROWS));
    col_ok     = !panel_column_i[COORD_W-1] && (col_ext < (COORD_W+1)'(COLUMNS));
    upper_half = row_ext >= (COORD_W+1)'(HALF_ROWS);
    row_local  = upper_half ? row_ext - (COORD_W+1)'(HALF_ROWS) : row_ext;
    pix_addr   = ADDR_W'(ROW_W'(row_local)) * ADDR_W'(COLUMNS)
               + ADDR_W'(COL_W'(col_ext));
    scan_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  end

  // write port: clearing pass or pixel write
  always_comb begin
    if (cmd_i.clear_step) begin
      wr_addr = clr_q;
      wr_data = '0;
      lo_we   = 1'b1;
      up_we   = 1'b1;
    end else begin
      wr_addr = pix_addr;
      wr_data = pixel_color_i;
      lo_we   = cmd_i.write_en && row_ok && col_ok && !upper_half;
      up_we   = cmd_i.write_en && row_ok && col_ok && upper_half;
    end
  end

  // memories with registered read
  always_ff @(posedge clk_i) begin
    if (lo_we) begin
      lo_mem_q[wr_addr] <= wr_data;
    end
    if (up_we) begin
      up_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.read_en) begin
      lo_rd_q <= lo_mem_q[scan_addr];
      up_rd_q <= up_mem_q[scan_addr];
    end
  end

  // counter next values
  always_comb begin
    clr_d = clr_q;
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.clear_step) begin
      clr_d = status_o.clear_last ? '0 : clr_q + ADDR_W'(1);
    end
    if (cmd_i.step_column) begin
      col_d = col_q + COL_W'(1);
    end
    if (cmd_i.next_row) begin
      col_d = '0;
      row_d = (row_q == ROW_W'(HALF_ROWS - 1)) ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else begin
      clr_q <= clr_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // status back to the controller
  assign status_o.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
  assign status_o.end_of_row = (col_q == COL_W'(COLUMNS - 1));

  // result fields: shift result from read data, latch result is constant but for row_address
  assign lower_rgb_o   = cmd_i.show_latch ? '0 : lo_rd_q;
  assign upper_rgb_o   = cmd_i.show_latch ? '0 : up_rd_q;
  assign shift_pulse_o = !cmd_i.show_latch;
  assign latch_pulse_o = cmd_i.show_latch;
  assign blank_o       = cmd_i.show_latch;
  assign row_address_o = ROW_ADDR_W'(row_q);
  assign last_o        = cmd_i.show_latch || !status_o.end_of_row;

endmodule

// File: hw/rtl/rlm_ctrl.sv
// scan controller state machine: clearing pass, item intake, result sequencing
// depends on rlm_pkg and the assertion macro header
`include "rgb_led_matrix_scan_controller_macros.svh"
module rlm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rlm_pkg::cmd_t    cmd_o,
  input  rlm_pkg::status_t status_i
);
  import rlm_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_LATCH
  } state_e;

  state_e state_q, state_d;

  // handshake follows the state
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SHIFT) || (state_q == ST_LATCH);

  // commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_TICK) begin
            cmd_o.read_en = 1'b1;
            state_d       = ST_SHIFT;
          end else begin
            cmd_o.write_en = 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        if (out_ready_i) begin
          if (status_i.end_of_row) begin
            state_d = ST_LATCH;
          end else begin
            cmd_o.step_column = 1'b1;
            state_d           = ST_IDLE;
          end
        end
      end
      ST_LATCH: begin
        cmd_o.show_latch = 1'b1;
        if (out_ready_i) begin
          cmd_o.next_row = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  `RLM_ASSERT(a_ready_valid_excl, !(in_ready_o && out_valid_o), "ready while result pending")
  `RLM_ASSERT(a_no_intake_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o, "item taken during clear")
  `RLM_ASSERT(a_tick_gives_result, (in_valid_i && in_ready_o && action_i == ACT_TICK) |=> (out_valid_o && !cmd_o.show_latch), "tick without shift result")
  `RLM_ASSERT(a_latch_after_row, (state_q == ST_SHIFT && out_ready_i && status_i.end_of_row) |=> (state_q == ST_LATCH), "end of row without latch")
  `RLM_ASSERT(a_latch_origin, $rose(cmd_o.show_latch) |-> ($past(state_q) == ST_SHIFT && $past(status_i.end_of_row)), "latch result out of place")

endmodule

// File: hw/rtl/rgb_led_matrix_scan_controller.sv
// top level of the led panel scan controller
// depends on rlm_pkg, rlm_ctrl and rlm_datapath
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  action, panel_row, panel_column, pixel_color
//  out      output     out_valid_o/out_ready_i lower_rgb, upper_rgb, shift_pulse,
//                                             latch_pulse, blank, row_address, last
//
// pixel writes can follow each other every cycle
// a tick reads the frame store in its accept cycle and shows the shift result the next
// cycle; at end of row the latch result follows once the shift result is taken
// after reset a clearing pass zeroes the HALF_ROWS*COLUMNS (2048 by default) entries
// of the frame store; no item is taken until it ends
// while a result waits on out_ready_i no input item is taken
module rgb_led_matrix_scan_controller #(
  parameter int HALF_ROWS = rlm_pkg::HALF_ROWS_DEF,
  parameter int COLUMNS   = rlm_pkg::COLUMNS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic signed [rlm_pkg::COORD_W-1:0]    panel_row_i,
  input  logic signed [rlm_pkg::COORD_W-1:0]    panel_column_i,
  input  logic        [rlm_pkg::COLOR_W-1:0]    pixel_color_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [rlm_pkg::COLOR_W-1:0]    lower_rgb_o,
  output logic        [rlm_pkg::COLOR_W-1:0]    upper_rgb_o,
  output logic                                  shift_pulse_o,
  output logic                                  latch_pulse_o,
  output logic                                  blank_o,
  output logic        [rlm_pkg::ROW_ADDR_W-1:0] row_address_o,
  output logic                                  last_o
);
  import rlm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  rlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // frame store and counters
  rlm_datapath #(
    .HALF_ROWS (HALF_ROWS),
    .COLUMNS   (COLUMNS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .panel_row_i    (panel_row_i),
    .panel_column_i (panel_column_i),
    .pixel_color_i  (pixel_color_i),
    .lower_rgb_o    (lower_rgb_o),
    .upper_rgb_o    (upper_rgb_o),
    .shift_pulse_o  (shift_pulse_o),
    .latch_pulse_o  (latch_pulse_o),
    .blank_o        (blank_o),
    .row_address_o  (row_address_o),
    .last_o         (last_o)
  );

endmodule

// File: verif/rgb_led_matrix_scan_controller_tb.sv
// testbench for the led panel scan controller: pixel writes and scan ticks,
// results predicted from a private copy of the frame store and scan counters
// depends on rlm_pkg and rgb_led_matrix_scan_controller
module rgb_led_matrix_scan_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlm_pkg::*;

  localparam int HALF = HALF_ROWS_DEF;
  localparam int COLS = COLUMNS_DEF;
  localparam int RANDOM_ITEMS = 2000;

  // one result of a tick
  typedef struct packed {
    logic [COLOR_W-1:0]    lower_rgb;
    logic [COLOR_W-1:0]    upper_rgb;
    logic                  shift_pulse;
    logic                  latch_pulse;
    logic                  blank;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  last;
  } scan_result_t;

  // frame store copy, scan position and the queue of results still to come
  class scan_scoreboard;
    logic [5:0]   frame [HALF*COLS];
    int           scan_row;
    int           scan_col;
    bit           row_wrapped;
    int           mismatches;
    scan_result_t expected_scan[$];

    function new();
      foreach (frame[i]) frame[i] = '0;
      scan_row    = 0;
      scan_col    = 0;
      row_wrapped = 0;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_scan.size();
    endfunction

    // a write that lands on the panel, anything else is dropped
    function bit lands(logic signed [COORD_W-1:0] row, logic signed [COORD_W-1:0] col);
      int r;
      int c;
      r = int'(row);
      c = int'(col);
      return (r >= 0) && (r < 2*HALF) && (c >= 0) && (c < COLS);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // update the predicted state for an accepted item
    function void note_item(logic act, logic signed [COORD_W-1:0] row,
                            logic signed [COORD_W-1:0] col, logic [COLOR_W-1:0] colour);
      int           r;
      int           c;
      int           idx;
      logic [5:0]   entry;
      bit           end_of_row;
      scan_result_t res;
      r = int'(row);
      c = int'(col);
      if (act == ACT_WRITE) begin
        if (!lands(row, col)) return;
        // only the addressed half of the entry changes
        if (r >= HALF) begin
          idx = (r - HALF) * COLS + c;
          frame[idx][5:3] = colour;
        end else begin
          idx = r * COLS + c;
          frame[idx][2:0] = colour;
        end
        return;
      end
      entry      = frame[scan_row * COLS + scan_col];
      end_of_row = (scan_col == COLS - 1);
      res.lower_rgb   = entry[2:0];
      res.upper_rgb   = entry[5:3];
      res.shift_pulse = 1'b1;
      res.latch_pulse = 1'b0;
      res.blank       = 1'b0;
      res.row_address = scan_row[ROW_ADDR_W-1:0];
      res.last        = !end_of_row;
      expected_scan.push_back(res);
      if (!end_of_row) begin
        scan_col++;
        return;
      end
      // latch and blank after the last column
      res = '0;
      res.latch_pulse = 1'b1;
      res.blank       = 1'b1;
      res.row_address = scan_row[ROW_ADDR_W-1:0];
      res.last        = 1'b1;
      expected_scan.push_back(res);
      scan_col = 0;
      if (scan_row == HALF - 1) begin
        scan_row    = 0;
        row_wrapped = 1;
      end else begin
        scan_row++;
      end
    endfunction

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_scan_result(scan_result_t got);
      scan_result_t want;
      if (expected_scan.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = expected_scan.pop_front();
      compare_field("lower_rgb", int'(got.lower_rgb), int'(want.lower_rgb));
      compare_field("upper_rgb", int'(got.upper_rgb), int'(want.upper_rgb));
      compare_field("shift_pulse", int'(got.shift_pulse), int'(want.shift_pulse));
      compare_field("latch_pulse", int'(got.latch_pulse), int'(want.latch_pulse));
      compare_field("blank", int'(got.blank), int'(want.blank));
      compare_field("row_address", int'(got.row_address), int'(want.row_address));
      compare_field("last", int'(got.last), int'(want.last));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic                         action_i       = ACT_WRITE;
  logic signed [COORD_W-1:0]    panel_row_i    = '0;
  logic signed [COORD_W-1:0]    panel_column_i = '0;
  logic        [COLOR_W-1:0]    pixel_color_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic        [COLOR_W-1:0]    lower_rgb_o;
  logic        [COLOR_W-1:0]    upper_rgb_o;
  logic                         shift_pulse_o;
  logic                         latch_pulse_o;
  logic                         blank_o;
  logic        [ROW_ADDR_W-1:0] row_address_o;
  logic                         last_o;

  scan_scoreboard sb = new();
  bit             sender_burst   = 0;
  bit             receiver_burst = 0;

  rgb_led_matrix_scan_controller u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .panel_row_i    (panel_row_i),
    .panel_column_i (panel_column_i),
    .pixel_color_i  (pixel_color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .lower_rgb_o    (lower_rgb_o),
    .upper_rgb_o    (upper_rgb_o),
    .shift_pulse_o  (shift_pulse_o),
    .latch_pulse_o  (latch_pulse_o),
    .blank_o        (blank_o),
    .row_address_o  (row_address_o),
    .last_o         (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // drive one item after a random gap, valid stays up if the next gap is zero
  task automatic send_item(logic act, logic signed [COORD_W-1:0] row,
                           logic signed [COORD_W-1:0] col, logic [COLOR_W-1:0] colour);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    panel_row_i    <= row;
    panel_column_i <= col;
    pixel_color_i  <= colour;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, row, col, colour);
  endtask

  // hold off input until every expected result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result sink with random stalls
  initial begin
    int           stall;
    scan_result_t got;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.lower_rgb   = lower_rgb_o;
      got.upper_rgb   = upper_rgb_o;
      got.shift_pulse = shift_pulse_o;
      got.latch_pulse = latch_pulse_o;
      got.blank       = blank_o;
      got.row_address = row_address_o;
      got.last        = last_o;
      sb.check_scan_result(got);
    end
  end

  // reset, directed items, random items, then wait for the tail
  initial begin
    int                        taken;
    int                        pick;
    logic                      act;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col;
    logic        [COLOR_W-1:0] colour;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // both halves of one entry, each keeping the other
    send_item(ACT_WRITE, 8'sd0, 8'sd0, 3'd7);
    send_item(ACT_WRITE, 8'sd32, 8'sd0, 3'd5);
    send_item(ACT_WRITE, 8'sd0, 8'sd0, 3'd2);
    send_item(ACT_WRITE, 8'sd0, 8'sd1, 3'd4);
    send_item(ACT_WRITE, 8'sd32, 8'sd1, 3'd1);
    send_item(ACT_WRITE, 8'sd31, 8'sd63, 3'd3);
    send_item(ACT_WRITE, 8'sd63, 8'sd63, 3'd6);
    // coordinates off the panel are dropped, then one write on the panel
    send_item(ACT_WRITE, -8'sd1, 8'sd2, 3'd7);
    send_item(ACT_WRITE, 8'sd64, 8'sd2, 3'd7);
    send_item(ACT_WRITE, 8'sd0, -8'sd128, 3'd7);
    send_item(ACT_WRITE, 8'sd0, 8'sd64, 3'd7);
    send_item(ACT_WRITE, 8'sd127, 8'sd127, 3'd7);
    send_item(ACT_WRITE, -8'sd128, -8'sd1, 3'd7);
    send_item(ACT_WRITE, 8'sd32, 8'sd2, 3'd0);
    // shift out the first columns
    send_item(ACT_TICK, 8'sd0, 8'sd0, 3'd0);
    send_item(ACT_TICK, -8'sd1, -8'sd1, 3'd7);
    send_item(ACT_TICK, 8'sd0, 8'sd0, 3'd0);
    send_item(ACT_TICK, 8'sd0, 8'sd0, 3'd0);
    drain_results();

    // random mix, kept going until RANDOM_ITEMS ticks and landing writes are taken and the scan row has wrapped once
    taken = 0;
    while (taken < RANDOM_ITEMS || !sb.row_wrapped) begin
      colour = COLOR_W'($urandom_range(0, 7));
      act    = ($urandom_range(0, 9) < 9) ? ACT_TICK : ACT_WRITE;
      pick   = $urandom_range(0, 99);
      if (act == ACT_TICK) begin
        row = COORD_W'($urandom_range(0, 255));
        col = COORD_W'($urandom_range(0, 255));
      end else if (pick < 50) begin
        // aim at the row being scanned so the write shows soon
        row = COORD_W'(sb.scan_row + ($urandom_range(0, 1) ? HALF : 0));
        col = COORD_W'($urandom_range(sb.scan_col, COLS - 1));
      end else if (pick < 85) begin
        row = COORD_W'($urandom_range(0, 2*HALF - 1));
        col = COORD_W'($urandom_range(0, COLS - 1));
      end else begin
        row = COORD_W'($urandom_range(0, 255));
        col = COORD_W'($urandom_range(0, 255));
      end
      if (act == ACT_TICK || sb.lands(row, col)) taken++;
      send_item(act, row, col, colour);
      if (taken == RANDOM_ITEMS / 2) drain_results();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
